// File: design/tjs_pkg.sv
package tjs_pkg;

  localparam int unsigned NumJointFields = 6;
  localparam int unsigned JointCountDefault = 6;
  localparam int unsigned FracBitsDefault = 24;
  localparam int unsigned DataW = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned SumW = 68;
  localparam int unsigned RootW = 34;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] ToolSpeedReset = 32'h0100_0000;
  localparam logic [31:0] JointLimitReset = 32'h0100_0000;

  // register indexes of the configuration port
  localparam logic [0:0] RegToolSpeed = 1'b0;
  localparam logic [0:0] RegJointLimit = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic                first;
    logic [DiffW-1:0]    maxdiff;
    logic [DiffW-1:0]    dx;
    logic [DiffW-1:0]    dy;
    logic [DiffW-1:0]    dz;
  } item_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkSquare,
    BkRoot,
    BkDivide,
    BkCompare,
    BkDone
  } bk_state_e;

endpackage

// File: design/tjs_front.sv
module tjs_front #(
  parameter int unsigned JointCount = tjs_pkg::JointCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 first_point_i,
  input  logic [6*32-1:0]      joints_i,
  input  logic [3*32-1:0]      tool_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output tjs_pkg::item_t       q_item_o
);
  import tjs_pkg::*;

  localparam int unsigned Nj = (JointCount < NumJointFields) ? JointCount : NumJointFields;

  logic [DataW-1:0] prev_j_q [NumJointFields];
  logic [DataW-1:0] prev_t_q [3];
  item_t            slot_q [QueueDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  item_t            item_d;

  function automatic logic [DiffW-1:0] absdiff(logic [DataW-1:0] a, logic [DataW-1:0] b);
    logic signed [DiffW-1:0] d;
    d = $signed({a[DataW-1], a}) - $signed({b[DataW-1], b});
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

  // classify: joint max over independent lanes, tool deltas
  always_comb begin
    logic [DiffW-1:0] d;
    item_d = '0;
    item_d.first = first_point_i;
    for (int j = 0; j < Nj; j++) begin
      d = absdiff(joints_i[j*DataW +: DataW], prev_j_q[j]);
      if (d > item_d.maxdiff) item_d.maxdiff = d;
    end
    item_d.dx = absdiff(tool_i[0 +: DataW], prev_t_q[0]);
    item_d.dy = absdiff(tool_i[DataW +: DataW], prev_t_q[1]);
    item_d.dz = absdiff(tool_i[2*DataW +: DataW], prev_t_q[2]);
  end

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = slot_q[rd_ptr_q];

  // previous waypoint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumJointFields; j++) prev_j_q[j] <= '0;
      for (int t = 0; t < 3; t++) prev_t_q[t] <= '0;
    end else if (push) begin
      for (int j = 0; j < NumJointFields; j++) prev_j_q[j] <= joints_i[j*DataW +: DataW];
      for (int t = 0; t < 3; t++) prev_t_q[t] <= tool_i[t*DataW +: DataW];
    end
  end

  // two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= item_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

// File: design/tjs_back.sv
module tjs_back #(
  parameter int unsigned FracBits = tjs_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  tjs_pkg::item_t   q_item_i,
  input  logic [31:0]      tool_speed_i,
  input  logic [31:0]      joint_limit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             starts_segment_o,
  output logic [31:0]      time_step_o,
  output logic             any_split_o,
  output logic             zero_move_o
);
  import tjs_pkg::*;

  localparam int unsigned NumW = RootW + FracBits;
  localparam int unsigned QCntW = $clog2(NumW + 1);

  bk_state_e         state_q, state_d;
  item_t             it_q;
  logic [1:0]        sq_idx_q;
  logic [SumW-1:0]   sum_q;
  logic [RootW-1:0]  root_q;
  logic [SumW-1:0]   rem_q;
  logic [5:0]        bit_q;
  logic [NumW-1:0]   num_q;
  logic [DataW:0]    drem_q;
  logic [QCntW-1:0]  dcnt_q;
  logic [1:0]        cmp_q;
  logic [65:0]       lhs_q, rhs_q;
  logic              split_seen_q;
  logic              res_valid_q;

  logic [DiffW-1:0]   sq_op;
  logic [2*DiffW-1:0] sq_prod;
  logic [65:0]        lhs_prod, rhs_prod;
  logic [SumW+1:0]    trial;
  logic [DataW:0]     dsh;
  logic               last_bit;

  // square one delta per cycle
  always_comb begin
    case (sq_idx_q)
      2'd0:    sq_op = it_q.dx;
      2'd1:    sq_op = it_q.dy;
      default: sq_op = it_q.dz;
    endcase
  end

  assign sq_prod = sq_op * sq_op;
  assign lhs_prod = tool_speed_i * it_q.maxdiff;
  assign rhs_prod = joint_limit_i * root_q;

  // restoring square root: remainder and root, one bit a cycle
  assign trial = {2'b00, rem_q[SumW-3:0], sum_q[SumW-1 -: 2]}
                 - {{(SumW+2-RootW-2){1'b0}}, root_q, 2'b01} ;
  assign dsh = {drem_q[DataW-1:0], num_q[NumW-1]};
  assign last_bit = (bit_q == 6'd0);

  assign q_ready_o = (state_q == BkIdle) && !res_valid_q;
  assign out_valid_o = res_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:    if (q_valid_i && q_ready_o) state_d = q_item_i.first ? BkDone : BkSquare;
      BkSquare:  if (sq_idx_q == 2'd2) state_d = BkRoot;
      BkRoot:    if (last_bit) state_d = BkDivide;
      BkDivide:  if (dcnt_q == QCntW'(NumW - 1)) state_d = BkCompare;
      BkCompare: if (cmp_q == 2'd2) state_d = BkDone;
      BkDone:    state_d = BkIdle;
      default:   state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_seen_q     <= 1'b0;
      res_valid_q      <= 1'b0;
      starts_segment_o <= 1'b0;
      time_step_o      <= '0;
      any_split_o      <= 1'b0;
      zero_move_o      <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) res_valid_q <= 1'b0;
      if (state_q == BkDone) begin
        res_valid_q <= 1'b1;
        if (it_q.first) begin
          split_seen_q <= 1'b0;
          starts_segment_o <= 1'b0;
          time_step_o <= '0;
          any_split_o <= 1'b0;
          zero_move_o <= 1'b0;
        end else begin
          starts_segment_o <= (lhs_q > rhs_q);
          any_split_o <= split_seen_q | (lhs_q > rhs_q);
          split_seen_q <= split_seen_q | (lhs_q > rhs_q);
          zero_move_o <= (root_q == '0);
          if (root_q == '0) time_step_o <= '0;
          else if (tool_speed_i == '0) time_step_o <= '1;
          else if (|num_q[NumW-1:DataW]) time_step_o <= '1;
          else time_step_o <= num_q[DataW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        it_q <= q_item_i;
        sq_idx_q <= 2'd0;
        sum_q <= '0;
      end
      BkSquare: begin
        sum_q <= sum_q + SumW'(sq_prod);
        sq_idx_q <= sq_idx_q + 2'd1;
        rem_q <= '0;
        root_q <= '0;
        bit_q <= 6'(RootW - 1);
      end
      BkRoot: begin
        sum_q <= {sum_q[SumW-3:0], 2'b00};
        if (!trial[SumW+1]) begin
          rem_q <= trial[SumW-1:0];
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[SumW-3:0], sum_q[SumW-1 -: 2]};
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        bit_q <= bit_q - 6'd1;
        if (last_bit) begin
          drem_q <= '0;
          dcnt_q <= '0;
        end
      end
      BkDivide: begin
        // restoring divide of root << FracBits by tool speed
        if (dsh >= {1'b0, tool_speed_i}) begin
          drem_q <= dsh - {1'b0, tool_speed_i};
          num_q <= {num_q[NumW-2:0], 1'b1};
        end else begin
          drem_q <= dsh;
          num_q <= {num_q[NumW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + QCntW'(1);
        cmp_q <= 2'd0;
      end
      BkCompare: begin
        // one product per cycle
        if (cmp_q == 2'd0) lhs_q <= lhs_prod;
        if (cmp_q == 2'd1) rhs_q <= rhs_prod;
        cmp_q <= cmp_q + 2'd1;
      end
      default: ;
    endcase
    // load dividend when root finishes
    if (state_q == BkRoot && last_bit) begin
      num_q <= {root_q[RootW-2:0], ~trial[SumW+1], {FracBits{1'b0}}};
    end
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_ready_o) |-> !res_valid_q) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkDone |=> res_valid_q) else $error("result lost");
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDone && it_q.first) |=> !split_seen_q) else $error("sticky not cleared");
endmodule

// File: design/trajectory_joint_speed_segmenter_core.sv
// Path from input transaction to result valid: queue hop, squares, bit-serial square root,
// bit-serial divide, products, result. A first point goes from idle straight to the result.
// The back end takes the next waypoint in the cycle after its result is accepted, so it
// works on one waypoint at a time; the front end queues two.
// Reset (rst_ni, async, active low): previous waypoint and sticky split flag cleared,
// tool speed and joint limit set to 1.0 in Q8.24.
module trajectory_joint_speed_segmenter_core #(
  parameter int unsigned JointCount = tjs_pkg::JointCountDefault,
  parameter int unsigned FracBits = tjs_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        first_point_i,
  input  logic [31:0] joint_0_i,
  input  logic [31:0] joint_1_i,
  input  logic [31:0] joint_2_i,
  input  logic [31:0] joint_3_i,
  input  logic [31:0] joint_4_i,
  input  logic [31:0] joint_5_i,
  input  logic [31:0] tool_x_i,
  input  logic [31:0] tool_y_i,
  input  logic [31:0] tool_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        starts_segment_o,
  output logic [31:0] time_step_o,
  output logic        any_split_o,
  output logic        zero_move_o
);
  import tjs_pkg::*;

  logic [31:0] tool_speed_q, joint_limit_q;
  logic        q_valid, q_ready;
  item_t       q_item;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tool_speed_q  <= ToolSpeedReset;
      joint_limit_q <= JointLimitReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegToolSpeed) tool_speed_q <= cfg_data_i;
      if (cfg_index_i == RegJointLimit) joint_limit_q <= cfg_data_i;
    end
  end

  tjs_front #(.JointCount(JointCount)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .first_point_i,
    .joints_i({joint_5_i, joint_4_i, joint_3_i, joint_2_i, joint_1_i, joint_0_i}),
    .tool_i({tool_z_i, tool_y_i, tool_x_i}),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  tjs_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .tool_speed_i(tool_speed_q), .joint_limit_i(joint_limit_q),
    .out_valid_o, .out_ready_i, .starts_segment_o, .time_step_o, .any_split_o,
    .zero_move_o
  );
endmodule
